@@ rtl/cbfi_pkg.sv @@
// Shared types and constants for the countdown bit-flip fault injector.
// Used by cbfi_step and countdown_bit_flip_fault_injector; no dependencies.
package cbfi_pkg;

	// Item kinds on the mode field; code 7 is unused and ignored
	typedef enum logic [2:0] {
		MODE_BLOCK = 3'd0,
		MODE_BIT   = 3'd1,
		MODE_BYTE  = 3'd2,
		MODE_HALF  = 3'd3,
		MODE_WORD  = 3'd4,
		MODE_DWORD = 3'd5,
		MODE_ADDR  = 3'd6
	} mode_t;

	localparam logic [2:0] MODE_UNUSED = 3'd7;

	// Configuration register indexes
	localparam logic [2:0] CFG_ENABLE       = 3'd0;
	localparam logic [2:0] CFG_HIST_MODE    = 3'd1;
	localparam logic [2:0] CFG_MAX_INTERVAL = 3'd2;
	localparam logic [2:0] CFG_INIT_COUNT   = 3'd3;
	localparam logic [2:0] CFG_BIT_POSITION = 3'd4;

	localparam int unsigned KIND_COUNT = 6;
	localparam logic [31:0] RAND_TOP   = 32'h7FFF_FFFF;
	localparam logic [6:0]  BIT_RANDOM = 7'h7F;   // bit position -1

	typedef struct packed {
		logic        enable;
		logic        hist_mode;
		logic [30:0] max_interval;
		logic [6:0]  flip_pos;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] value;
		logic        once_req;
		logic [15:0] block_sites;
		logic [30:0] bit_random;
		logic [61:0] reload_prod;   // reload_random * max_interval
	} item_t;

	typedef struct packed {
		logic signed [31:0] countdown;
		logic [63:0]        site_total;
		logic [31:0]        inj_count;
		logic               once_data;
		logic               once_address;
		logic               block_no_fault;
	} state_t;

	typedef struct packed {
		logic [63:0] value_out;
		logic        injected;
		logic [5:0]  bit_used;
		logic        fault_in_block;
		logic [63:0] total_sites;
		logic [31:0] injection_total;
		logic [31:0] kind_sites;
	} result_t;

endpackage

@@ rtl/countdown_bit_flip_fault_injector.sv @@
// Top level of the countdown bit-flip fault injector: ports, config registers,
// pipeline and state registers. Depends on cbfi_pkg and cbfi_step.
//
// The injector takes one beat per cycle while in_ready is high and returns
// one result beat for each input beat. A beat accepted at a clock edge is
// held in the input register, processed by cbfi_step once the result stage
// can advance, and its result is loaded into the result register and shown
// on the output. The first register stage
// captures the item together with the reload product (reload_random times
// max_interval, one 31x31 multiply); the second stage runs the countdown,
// counters and bit flip in cbfi_step against the state registers and loads the
// result register. A stalled result holds in the output register while a new
// beat still enters the first stage; in_ready follows out_ready in the same
// cycle once both stages are full. Configuration writes are taken in every
// cycle (cfg_ready is always high); writing initial_countdown also loads the
// live countdown. Index values 5 to 7 are accepted and dropped.
module countdown_bit_flip_fault_injector (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [63:0] value,
	input  logic        once_req,
	input  logic [15:0] block_sites,
	input  logic [30:0] bit_random,
	input  logic [30:0] reload_random,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value_out,
	output logic        injected,
	output logic [5:0]  bit_used,
	output logic        fault_in_block,
	output logic [63:0] total_sites,
	output logic [31:0] injection_total,
	output logic [31:0] kind_sites
);

	cbfi_pkg::cfg_t    cfg_q;
	cbfi_pkg::item_t   item_s1;
	cbfi_pkg::state_t  state_q;
	cbfi_pkg::state_t  state_nxt;
	cbfi_pkg::result_t res_d;
	cbfi_pkg::result_t res_s2;

	logic        valid_s1;
	logic        valid_s2;
	logic        advance;
	logic        step_go;
	logic        kind_we;
	logic [31:0] kind_next;
	logic [31:0] kind_cnt;
	logic [2:0]  kind_idx;
	logic [31:0] kind_q [cbfi_pkg::KIND_COUNT];

	assign cfg_ready = 1'b1;

	// The result stage moves when it is empty or being drained
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step_go  = valid_s1 && advance;

	// Per-kind counter for the item in stage one; mode 0 and 7 read as zero
	assign kind_idx = item_s1.mode - 3'd1;
	assign kind_cnt = (item_s1.mode != cbfi_pkg::MODE_BLOCK
		&& item_s1.mode != cbfi_pkg::MODE_UNUSED) ? kind_q[kind_idx] : 32'd0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable       <= 1'b1;
			cfg_q.hist_mode    <= 1'b0;
			cfg_q.max_interval <= '0;
			cfg_q.flip_pos     <= cbfi_pkg::BIT_RANDOM;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbfi_pkg::CFG_ENABLE:       cfg_q.enable       <= cfg_data[0];
				cbfi_pkg::CFG_HIST_MODE:    cfg_q.hist_mode    <= cfg_data[0];
				cbfi_pkg::CFG_MAX_INTERVAL: cfg_q.max_interval <= cfg_data[30:0];
				cbfi_pkg::CFG_BIT_POSITION: cfg_q.flip_pos     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Stage one: capture the beat and the reload product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode        <= mode;
			item_s1.value       <= value;
			item_s1.once_req    <= once_req;
			item_s1.block_sites <= block_sites;
			item_s1.bit_random  <= bit_random;
			item_s1.reload_prod <= 62'(reload_random) * 62'(cfg_q.max_interval);
		end
	end

	cbfi_step u_step (
		.cfg       (cfg_q),
		.item      (item_s1),
		.st        (state_q),
		.kind_cnt  (kind_cnt),
		.nxt       (state_nxt),
		.kind_we   (kind_we),
		.kind_next (kind_next),
		.res       (res_d)
	);

	// Injector state: advance once per processed beat; a countdown write wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.countdown      <= '1;
			state_q.site_total     <= '0;
			state_q.inj_count      <= '0;
			state_q.once_data      <= 1'b0;
			state_q.once_address   <= 1'b0;
			state_q.block_no_fault <= 1'b1;
		end else begin
			if (step_go)
				state_q <= state_nxt;
			if (cfg_valid && cfg_index == cbfi_pkg::CFG_INIT_COUNT)
				state_q.countdown <= $signed(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbfi_pkg::KIND_COUNT; i++)
				kind_q[i] <= '0;
		end else if (step_go && kind_we) begin
			kind_q[kind_idx] <= kind_next;
		end
	end

	// Stage two: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_go)
			res_s2 <= res_d;
	end

	assign out_valid       = valid_s2;
	assign value_out       = res_s2.value_out;
	assign injected        = res_s2.injected;
	assign bit_used        = res_s2.bit_used;
	assign fault_in_block  = res_s2.fault_in_block;
	assign total_sites     = res_s2.total_sites;
	assign injection_total = res_s2.injection_total;
	assign kind_sites      = res_s2.kind_sites;

endmodule

@@ rtl/cbfi_step.sv @@
// Next-state and result logic for one item of the fault injector.
// Depends on cbfi_pkg; purely combinational, registered by the top level.
module cbfi_step (
	input  cbfi_pkg::cfg_t    cfg,
	input  cbfi_pkg::item_t   item,
	input  cbfi_pkg::state_t  st,
	input  logic [31:0]       kind_cnt,
	output cbfi_pkg::state_t  nxt,
	output logic              kind_we,
	output logic [31:0]       kind_next,
	output cbfi_pkg::result_t res
);

	always_comb begin
		logic [63:0]        mask;
		logic [5:0]         wmask;
		logic               latch_d;
		logic               latch_a;
		logic               cur_latch;
		logic               fire;
		logic               ok;
		logic [5:0]         b;
		logic [30:0]        h;
		logic [30:0]        l;
		logic [31:0]        hsum;
		logic [31:0]        q;
		logic signed [32:0] cd_x;
		logic signed [32:0] sites_x;

		nxt       = st;
		kind_we   = 1'b0;
		kind_next = kind_cnt + 32'd1;
		res       = '0;
		fire      = 1'b0;
		ok        = 1'b0;
		b         = '0;
		latch_d   = st.once_data;
		latch_a   = st.once_address;
		cur_latch = 1'b0;

		// reload = floor(prod / (2^31-1)): prod = h*2^31 + l = h*M + (h + l)
		h    = item.reload_prod[61:31];
		l    = item.reload_prod[30:0];
		hsum = {1'b0, h} + {1'b0, l};
		q    = {1'b0, h};
		if (hsum >= {cbfi_pkg::RAND_TOP[30:0], 1'b0})
			q = {1'b0, h} + 32'd2;
		else if (hsum >= cbfi_pkg::RAND_TOP)
			q = {1'b0, h} + 32'd1;

		cd_x    = {st.countdown[31], st.countdown};
		sites_x = $signed({17'b0, item.block_sites});

		unique case (item.mode)
			cbfi_pkg::MODE_BIT:   begin mask = 64'h1;                   wmask = 6'd0;  end
			cbfi_pkg::MODE_BYTE:  begin mask = 64'hFF;                  wmask = 6'd7;  end
			cbfi_pkg::MODE_HALF:  begin mask = 64'hFFFF;                wmask = 6'd15; end
			cbfi_pkg::MODE_WORD:  begin mask = 64'hFFFF_FFFF;           wmask = 6'd31; end
			default:              begin mask = 64'hFFFF_FFFF_FFFF_FFFF; wmask = 6'd63; end
		endcase

		if (item.mode == cbfi_pkg::MODE_BLOCK) begin
			if (cfg.enable) begin
				if (cfg.hist_mode) begin
					nxt.block_no_fault = 1'b0;
				end else if (cd_x <= sites_x) begin
					if (!st.countdown[31])
						nxt.block_no_fault = 1'b0;
					else
						nxt.site_total = st.site_total + {48'b0, item.block_sites};
				end else begin
					nxt.site_total     = st.site_total + {48'b0, item.block_sites};
					nxt.countdown      = st.countdown - $signed({16'b0, item.block_sites});
					nxt.block_no_fault = 1'b1;
				end
			end
		end else if (item.mode != cbfi_pkg::MODE_UNUSED) begin
			res.value_out = item.value & mask;
			if (cfg.enable) begin
				nxt.site_total = st.site_total + 64'd1;
				kind_we        = 1'b1;
				if (item.mode == cbfi_pkg::MODE_ADDR)
					latch_a = st.once_address | item.once_req;
				else
					latch_d = st.once_data | item.once_req;
				nxt.once_data    = latch_d;
				nxt.once_address = latch_a;
				cur_latch = (item.mode == cbfi_pkg::MODE_ADDR) ? latch_a : latch_d;
				if (!(cur_latch && st.inj_count != 32'd0) && !st.countdown[31]) begin
					if (st.countdown[31:1] == 31'd0) begin
						// countdown expires: reload from the draw unless a latch is set or max_interval is zero
						if (!(latch_d || latch_a) && cfg.max_interval != 31'd0)
							nxt.countdown = $signed({1'b0, q[30:0]});
						else
							nxt.countdown = '1;
						nxt.block_no_fault = 1'b1;
						fire = 1'b1;
					end else begin
						nxt.countdown = st.countdown - 32'sd1;
					end
				end
				if (fire) begin
					if (item.mode == cbfi_pkg::MODE_BIT) begin
						ok = (cfg.flip_pos == 7'd0);
					end else if (cfg.flip_pos == cbfi_pkg::BIT_RANDOM) begin
						b  = item.bit_random[5:0] & wmask;
						ok = 1'b1;
					end else if (!cfg.flip_pos[6] && (cfg.flip_pos[5:0] & ~wmask) == 6'd0) begin
						b  = cfg.flip_pos[5:0];
						ok = 1'b1;
					end
					if (ok) begin
						if (st.inj_count != 32'hFFFF_FFFF)
							nxt.inj_count = st.inj_count + 32'd1;
						res.value_out = res.value_out ^ (64'd1 << b);
						res.injected  = 1'b1;
						res.bit_used  = b;
					end
				end
				res.kind_sites = kind_next;
			end else begin
				res.kind_sites = kind_cnt;
			end
		end

		res.fault_in_block  = cfg.enable & ~nxt.block_no_fault;
		res.total_sites     = nxt.site_total;
		res.injection_total = nxt.inj_count;
	end

endmodule

@@ rtl/cbfi_checker.sv @@
// Port-level checks for the fault injector, bound to the top level.
// Depends only on the ports of countdown_bit_flip_fault_injector.
module cbfi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value_out,
	input logic        injected,
	input logic [5:0]  bit_used,
	input logic [63:0] total_sites,
	input logic [31:0] injection_total
);

	logic [31:0] last_inj_q;

	// Hold the injection total of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_inj_q <= '0;
		else if (out_valid && out_ready)
			last_inj_q <= injection_total;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(total_sites))
		else $error("result beat changed while stalled");

	a_inj_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && injected |-> injection_total != 32'd0)
		else $error("flip reported with zero injection total");

	a_no_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !injected |-> bit_used == 6'd0)
		else $error("bit index reported without a flip");

	a_inj_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> injection_total >= last_inj_q)
		else $error("injection total went down");

endmodule

bind countdown_bit_flip_fault_injector cbfi_checker u_cbfi_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.value_out       (value_out),
	.injected        (injected),
	.bit_used        (bit_used),
	.total_sites     (total_sites),
	.injection_total (injection_total)
);
